// ----- hdl/brs_pkg.sv -----
// Shared constants, codes and the queued command type of the bilinear raster sampler.
`timescale 1ns / 1ps

package brs_pkg;

    // Default sizes for the top level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed field widths
    localparam int POS_W     = 17;     // signed fixed-point position
    localparam int PIX_W     = 16;     // raw and normalized pixel
    localparam int DIM_W     = 9;      // raster width / height registers
    localparam int COORD_W   = DIM_W;  // clamped pixel coordinate, below any dimension
    localparam int FRAC_MAX  = 16;     // room for the largest fraction field
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Depth of the command queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOB       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd2;

    // Pixel format
    localparam logic FMT_GREY8  = 1'b0;
    localparam logic FMT_GREY16 = 1'b1;

    // Command kinds passed from front to back end
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_REPLY  = 2'd2;  // status-only answer

    typedef struct packed {
        logic [1:0]          kind;
        logic [STAT_W-1:0]   status;
        logic [COORD_W-1:0]  x0;
        logic [COORD_W-1:0]  x1;
        logic [COORD_W-1:0]  y0;
        logic [COORD_W-1:0]  y1;
        logic [FRAC_MAX-1:0] fx;
        logic [FRAC_MAX-1:0] fy;
        logic [PIX_W-1:0]    wval;
    } op_t;

endpackage

// ----- hdl/brs_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module brs_ram #(
    parameter int WIDTH = brs_pkg::PIX_W,
    parameter int DEPTH = brs_pkg::MAX_WIDTH_DEF * brs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/brs_front.sv -----
// Front end: takes command beats, floors and clamps positions, classifies into queue ops.
`timescale 1ns / 1ps

module brs_front #(
    parameter int FRAC_BITS = brs_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic signed [brs_pkg::POS_W-1:0]  x_pos,
    input  logic signed [brs_pkg::POS_W-1:0]  y_pos,
    input  logic [brs_pkg::PIX_W-1:0]         write_value,
    input  logic [brs_pkg::DIM_W-1:0]         raster_width,
    input  logic [brs_pkg::DIM_W-1:0]         raster_height,
    input  logic                              pixel_format,
    input  logic                              q_full,
    output logic                              push,
    output brs_pkg::op_t                      push_op
);

    // Compare width: position width plus one, room for the floored position and the 9-bit dimensions, all signed
    localparam int CW = brs_pkg::POS_W + 1;

    logic                             hold_valid_reg;
    logic                             hold_valid_next;
    logic                             func_reg;
    logic signed [brs_pkg::POS_W-1:0] x_reg;
    logic signed [brs_pkg::POS_W-1:0] y_reg;
    logic [brs_pkg::PIX_W-1:0]        wval_reg;
    logic                             accept;

    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bx1;
    logic signed [CW-1:0] by1;
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] h_s;
    logic                 out_of_bounds;
    logic                 too_large;
    logic                 empty_raster;

    function automatic logic [brs_pkg::COORD_W-1:0] clamp_coord(
        input logic signed [CW-1:0] c,
        input logic signed [CW-1:0] dim
    );
        logic signed [CW-1:0] r;
        if (c < 0)
        begin
            r = '0;
        end
        else if (c >= dim)
        begin
            r = CW'(dim - 1);
        end
        else
        begin
            r = c;
        end
        return brs_pkg::COORD_W'(r);
    endfunction

    // Handshake: one holding stage, drained into the queue when it has room
    assign push   = hold_valid_reg && !q_full;
    assign busy   = hold_valid_reg && q_full;
    assign accept = start && !busy;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            x_reg    <= x_pos;
            y_reg    <= y_pos;
            wval_reg <= write_value;
        end
    end

    // Floor of the position and its right/lower neighbor
    always_comb
    begin
        bx  = CW'(x_reg >>> FRAC_BITS);
        by  = CW'(y_reg >>> FRAC_BITS);
        bx1 = bx + CW'(1);
        by1 = by + CW'(1);
        w_s = $signed(CW'(raster_width));
        h_s = $signed(CW'(raster_height));
    end

    // Classification
    assign out_of_bounds = (bx < 0) || (by < 0) || (bx >= w_s) || (by >= h_s);
    assign too_large     = (pixel_format == brs_pkg::FMT_GREY8) &&
                           (wval_reg[brs_pkg::PIX_W-1:8] != '0);
    assign empty_raster  = (raster_width == '0) || (raster_height == '0);

    always_comb
    begin
        push_op.x0   = clamp_coord(bx, w_s);
        push_op.x1   = clamp_coord(bx1, w_s);
        push_op.y0   = clamp_coord(by, h_s);
        push_op.y1   = clamp_coord(by1, h_s);
        push_op.fx   = brs_pkg::FRAC_MAX'(x_reg[FRAC_BITS-1:0]);
        push_op.fy   = brs_pkg::FRAC_MAX'(y_reg[FRAC_BITS-1:0]);
        push_op.wval = wval_reg;
        if (!func_reg)
        begin
            // bounds check comes before the value check
            if (out_of_bounds)
            begin
                push_op.kind   = brs_pkg::OP_REPLY;
                push_op.status = brs_pkg::STAT_OOB;
            end
            else if (too_large)
            begin
                push_op.kind   = brs_pkg::OP_REPLY;
                push_op.status = brs_pkg::STAT_TOO_LARGE;
            end
            else
            begin
                push_op.kind   = brs_pkg::OP_WRITE;
                push_op.status = brs_pkg::STAT_OK;
            end
        end
        else if (empty_raster)
        begin
            push_op.kind   = brs_pkg::OP_REPLY;
            push_op.status = brs_pkg::STAT_EMPTY;
        end
        else
        begin
            push_op.kind   = brs_pkg::OP_SAMPLE;
            push_op.status = brs_pkg::STAT_OK;
        end
    end

endmodule

// ----- hdl/brs_queue.sv -----
// Short FIFO of classified ops between front and back end.
`timescale 1ns / 1ps

module brs_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  brs_pkg::op_t push_op,
    input  logic         pop,
    output brs_pkg::op_t head,
    output logic         empty,
    output logic         full
);

    localparam int DEPTH = brs_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    brs_pkg::op_t     slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
`endif

endmodule

// ----- hdl/brs_back.sv -----
// Back end: executes queued ops on the pixel RAM and blends four neighbors.
`timescale 1ns / 1ps

module brs_back #(
    parameter int MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = brs_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  brs_pkg::op_t                head,
    input  logic                        empty,
    output logic                        pop,
    input  logic                        pixel_format,
    output logic                        done,
    output logic [brs_pkg::PIX_W-1:0]   sample_value,
    output logic [brs_pkg::STAT_W-1:0]  status
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int TOP_W  = brs_pkg::PIX_W + FRAC_BITS;  // one row blend, exact
    localparam int WGT_W  = FRAC_BITS + 1;               // weight up to 1.0
    localparam int PROD_W = TOP_W + WGT_W;
    localparam logic [WGT_W-1:0]  ONE_W = WGT_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (2 * FRAC_BITS - 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SAMPLE = 1'b1;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(6);

    logic                        state_reg;
    logic                        state_next;
    logic [STEP_W-1:0]           step_reg;
    logic [STEP_W-1:0]           step_next;
    logic                        done_reg;
    logic                        done_next;
    logic [brs_pkg::PIX_W-1:0]   sample_reg;
    logic [brs_pkg::PIX_W-1:0]   sample_next;
    logic [brs_pkg::STAT_W-1:0]  status_reg;
    logic [brs_pkg::STAT_W-1:0]  status_next;
    logic                        load_op;

    brs_pkg::op_t                op_reg;
    logic [TOP_W-1:0]            top_reg;
    logic [TOP_W-1:0]            bot_reg;
    logic [PROD_W-1:0]           acc_reg;
    logic [PROD_W-1:0]           prod_reg;

    logic [brs_pkg::COORD_W-1:0] rd_x;
    logic [brs_pkg::COORD_W-1:0] rd_y;
    logic [AW-1:0]               ram_addr;
    logic                        ram_we;
    logic [brs_pkg::PIX_W-1:0]   ram_rdata;
    logic [brs_pkg::PIX_W-1:0]   pix_norm;

    logic [WGT_W-1:0]            wx0;
    logic [WGT_W-1:0]            wx1;
    logic [WGT_W-1:0]            wy0;
    logic [WGT_W-1:0]            wy1;
    logic [TOP_W-1:0]            mul_a;
    logic [WGT_W-1:0]            mul_b;
    logic [PROD_W-1:0]           blend_sum;
    logic [PROD_W-2*FRAC_BITS-1:0] blend_q;
    logic [brs_pkg::PIX_W-1:0]   blend_sat;

    // Pixel store
    brs_ram #(
        .WIDTH (brs_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.wval),
        .rdata (ram_rdata)
    );

    // Address sequence: s00 at pop, then s10, s01, s11
    always_comb
    begin
        rd_x = head.x0;
        rd_y = head.y0;
        if (state_reg == S_SAMPLE)
        begin
            case (step_reg)
                3'd0:
                begin
                    rd_x = op_reg.x1;
                    rd_y = op_reg.y0;
                end
                3'd1:
                begin
                    rd_x = op_reg.x0;
                    rd_y = op_reg.y1;
                end
                default:
                begin
                    rd_x = op_reg.x1;
                    rd_y = op_reg.y1;
                end
            endcase
        end
    end

    assign ram_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);

    // 8-bit pixels scale by 257, i.e. the byte repeated
    assign pix_norm = (pixel_format == brs_pkg::FMT_GREY8) ? {ram_rdata[7:0], ram_rdata[7:0]}
                                                           : ram_rdata;

    // Blend weights
    assign wx1 = WGT_W'(op_reg.fx[FRAC_BITS-1:0]);
    assign wx0 = ONE_W - wx1;
    assign wy1 = WGT_W'(op_reg.fy[FRAC_BITS-1:0]);
    assign wy0 = ONE_W - wy1;

    // Shared multiplier: four pixel products, then the two row products
    always_comb
    begin
        case (step_reg) inside
            [3'd0:3'd3]:
            begin
                mul_a = TOP_W'(pix_norm);
                mul_b = step_reg[0] ? wx1 : wx0;
            end
            3'd4:
            begin
                mul_a = top_reg;
                mul_b = wy0;
            end
            default:
            begin
                mul_a = bot_reg;
                mul_b = wy1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Accumulation of rows and final sum
    always_ff @(posedge clk)
    begin
        if (load_op)
        begin
            op_reg <= head;
        end
        if (state_reg == S_SAMPLE)
        begin
            case (step_reg)
                3'd1:    top_reg <= TOP_W'(prod_reg);
                3'd2:    top_reg <= top_reg + TOP_W'(prod_reg);
                3'd3:    bot_reg <= TOP_W'(prod_reg);
                3'd4:    bot_reg <= bot_reg + TOP_W'(prod_reg);
                3'd5:    acc_reg <= prod_reg + ROUND;
                default: ;
            endcase
        end
    end

    // Round half up once, then drop the fraction bits
    assign blend_sum = acc_reg + prod_reg;
    assign blend_q   = blend_sum[PROD_W-1:2*FRAC_BITS];
    assign blend_sat = blend_q[brs_pkg::PIX_W] ? '1 : blend_q[brs_pkg::PIX_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        load_op     = 1'b0;
        done_next   = 1'b0;
        sample_next = sample_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        brs_pkg::OP_WRITE:
                        begin
                            ram_we      = 1'b1;
                            done_next   = 1'b1;
                            sample_next = '0;
                            status_next = brs_pkg::STAT_OK;
                        end
                        brs_pkg::OP_SAMPLE:
                        begin
                            load_op    = 1'b1;
                            state_next = S_SAMPLE;
                            step_next  = '0;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            sample_next = '0;
                            status_next = head.status;
                        end
                    endcase
                end
            end
            S_SAMPLE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    sample_next = blend_sat;
                    status_next = brs_pkg::STAT_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign sample_value = sample_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_sample_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SAMPLE && step_reg == LAST_STEP) |=> done_reg)
        else $error("sample finished without a result beat");

    a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != brs_pkg::STAT_OK) |-> (sample_reg == '0))
        else $error("nonzero sample on an error status");

    a_write_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE && !empty))
        else $error("pixel write outside idle dispatch");
`endif

endmodule

// ----- hdl/bilinear_raster_sampler.sv -----
// Top level of the bilinear raster sampler: config registers, front end, queue, back end.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  command  | start / busy           | func, x_pos, y_pos, write_value
//  result   | done (one-cycle beat)  | sample_value, status
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A write or rejected command is finished in the back end's idle dispatch; a
// sample runs the step sequence: four neighbor reads on the single RAM port,
// overlapped with six products on one shared multiplier and the final round.
// A holding stage and a two-deep queue let the front take commands while the
// back end works; busy rises only when both are full. Results cannot be
// stalled. Reset clears control state and the config registers; the pixel
// store is not cleared.
`timescale 1ns / 1ps

module bilinear_raster_sampler #(
    parameter int MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = brs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic signed [brs_pkg::POS_W-1:0]     x_pos,
    input  logic signed [brs_pkg::POS_W-1:0]     y_pos,
    input  logic [brs_pkg::PIX_W-1:0]            write_value,
    output logic                                 done,
    output logic [brs_pkg::PIX_W-1:0]            sample_value,
    output logic [brs_pkg::STAT_W-1:0]           status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [brs_pkg::DIM_W-1:0]            cfg_data
);

    logic [brs_pkg::DIM_W-1:0] raster_width_reg;
    logic [brs_pkg::DIM_W-1:0] raster_height_reg;
    logic                      pixel_format_reg;
    logic [brs_pkg::DIM_W-1:0] width_clamped;
    logic [brs_pkg::DIM_W-1:0] height_clamped;

    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    logic                      q_full;
    brs_pkg::op_t              q_in;
    brs_pkg::op_t              q_head;

    // Config port: always ready, dimensions limited to the store size
    assign cfg_ready = 1'b1;

    assign width_clamped  = (32'(cfg_data) > 32'(MAX_WIDTH))  ? brs_pkg::DIM_W'(MAX_WIDTH)
                                                              : cfg_data;
    assign height_clamped = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? brs_pkg::DIM_W'(MAX_HEIGHT)
                                                              : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_width_reg  <= '0;
            raster_height_reg <= '0;
            pixel_format_reg  <= brs_pkg::FMT_GREY8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brs_pkg::REG_WIDTH:  raster_width_reg  <= width_clamped;
                brs_pkg::REG_HEIGHT: raster_height_reg <= height_clamped;
                brs_pkg::REG_FORMAT: pixel_format_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    brs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .write_value   (write_value),
        .raster_width  (raster_width_reg),
        .raster_height (raster_height_reg),
        .pixel_format  (pixel_format_reg),
        .q_full        (q_full),
        .push          (q_push),
        .push_op       (q_in)
    );

    brs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    brs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .pixel_format (pixel_format_reg),
        .done         (done),
        .sample_value (sample_value),
        .status       (status)
    );

endmodule
